@@ hw/rtl/rotary_knob_led_cursor_assert.svh @@
`ifndef ROTARY_KNOB_LED_CURSOR_ASSERT_SVH
`define ROTARY_KNOB_LED_CURSOR_ASSERT_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define RKLC_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define RKLC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/rklc_pkg.sv @@
package rklc_pkg;

    localparam int CursorPositions = 16;
    localparam int CursorW         = $clog2(CursorPositions);
    localparam int CursorOutW      = 4;
    localparam int LedW            = 16;
    localparam int TicksW          = 32;

    localparam logic [TicksW-1:0] TicksReset = TicksW'(2000000);

    localparam logic [CursorW-1:0] CursorFirst = '0;
    localparam logic [CursorW-1:0] CursorLast  = CursorW'(CursorPositions - 1);

    // Decoder phases, coded as the {B, A} pin pattern that each stands for.
    localparam logic [1:0] Ph11 = 2'b11;
    localparam logic [1:0] Ph01 = 2'b01;
    localparam logic [1:0] Ph00 = 2'b00;
    localparam logic [1:0] Ph10 = 2'b10;

    typedef logic [CursorW-1:0] t_pos;

    typedef struct packed {
        logic cw;
        logic ccw;
    } t_step;

endpackage

@@ hw/rtl/rklc_in_if.sv @@
interface rklc_in_if;
    logic valid;
    logic ready;
    logic pin_a;
    logic pin_b;
    logic push_level;

    modport source (output valid, output pin_a, output pin_b, output push_level, input ready);
    modport sink   (input valid, input pin_a, input pin_b, input push_level, output ready);
endinterface

@@ hw/rtl/rklc_out_if.sv @@
interface rklc_out_if
    import rklc_pkg::*;
;
    logic                  valid;
    logic                  ready;
    logic [LedW-1:0]       led_pattern;
    logic [CursorOutW-1:0] cursor;
    logic                  display_on;

    modport source (output valid, output led_pattern, output cursor, output display_on,
                    input ready);
    modport sink   (input valid, input led_pattern, input cursor, input display_on,
                    output ready);
endinterface

@@ hw/rtl/rklc_cfg_if.sv @@
interface rklc_cfg_if
    import rklc_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [TicksW-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ hw/rtl/rklc_decoder.sv @@
module rklc_decoder
    import rklc_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_take,
    input  logic  i_pin_a,
    input  logic  i_pin_b,
    output t_step o_step
);

    logic [1:0] r_phase;
    logic [1:0] n_phase;
    logic [1:0] ab;

    assign ab = {i_pin_b, i_pin_a};

    always_comb begin
        n_phase = r_phase;
        o_step  = '0;
        unique case (r_phase)
            Ph01: begin
                if (ab == Ph00) begin
                    n_phase = Ph00;
                end else if (ab == Ph11) begin
                    n_phase    = Ph11;
                    o_step.ccw = 1'b1;
                end
            end
            Ph10: begin
                if (ab == Ph00) begin
                    n_phase = Ph00;
                end else if (ab == Ph11) begin
                    n_phase   = Ph11;
                    o_step.cw = 1'b1;
                end
            end
            default: begin
                if (ab == Ph01) begin
                    n_phase = Ph01;
                end else if (ab == Ph10) begin
                    n_phase = Ph10;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= Ph11;
        end else if (i_take) begin
            r_phase <= n_phase;
        end
    end

endmodule

@@ hw/rtl/rklc_debounce.sv @@
module rklc_debounce
    import rklc_pkg::*;
(
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_take,
    input  logic           i_push_level,
    rklc_cfg_if.sink       i_cfg,
    output logic           o_display
);

    logic [TicksW-1:0] r_ticks;
    logic [TicksW-1:0] r_count;
    logic [TicksW-1:0] n_count;
    logic              r_prev;
    logic              r_active;
    logic              n_active;
    logic              r_display;
    logic              rise;
    logic [TicksW-1:0] count_now;

    assign i_cfg.ready = 1'b1;

    assign rise      = i_push_level && !r_prev && !r_active;
    assign count_now = rise ? '0 : r_count;

    always_comb begin
        n_active  = r_active;
        n_count   = r_count;
        o_display = r_display;
        if (rise || r_active) begin
            if (count_now >= r_ticks) begin
                n_active  = 1'b0;
                n_count   = count_now;
                o_display = !r_display;
            end else begin
                n_active = 1'b1;
                n_count  = count_now + TicksW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ticks <= TicksReset;
        end else if (i_cfg.valid) begin
            r_ticks <= i_cfg.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev    <= 1'b0;
            r_active  <= 1'b0;
            r_count   <= '0;
            r_display <= 1'b1;
        end else if (i_take) begin
            r_prev    <= i_push_level;
            r_active  <= n_active;
            r_count   <= n_count;
            r_display <= o_display;
        end
    end

endmodule

@@ hw/rtl/rklc_cursor.sv @@
module rklc_cursor
    import rklc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_take,
    input  t_step       i_step,
    input  logic        i_display,
    output logic        o_busy,
    rklc_out_if.source  o_result
);

    t_pos                  r_pos;
    t_pos                  n_pos;
    logic                  r_valid;
    logic [LedW-1:0]       r_led;
    logic [LedW-1:0]       n_led;
    logic [CursorOutW-1:0] r_cursor;
    logic                  r_disp;

    always_comb begin
        n_pos = r_pos;
        if (i_display) begin
            if (i_step.cw) begin
                n_pos = (r_pos == CursorLast) ? CursorFirst : r_pos + CursorW'(1);
            end else if (i_step.ccw) begin
                n_pos = (r_pos == CursorFirst) ? CursorLast : r_pos - CursorW'(1);
            end
        end
        for (int k = 0; k < LedW; k++) begin
            n_led[k] = i_display && (int'(n_pos) == k);
        end
    end

    assign o_busy = r_valid && !o_result.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= CursorFirst;
            r_valid <= 1'b0;
        end else begin
            if (i_take) begin
                r_pos   <= n_pos;
                r_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_take) begin
            r_led    <= n_led;
            r_cursor <= CursorOutW'(n_pos);
            r_disp   <= i_display;
        end
    end

    assign o_result.valid       = r_valid;
    assign o_result.led_pattern = r_led;
    assign o_result.cursor      = r_cursor;
    assign o_result.display_on  = r_disp;

endmodule

@@ hw/rtl/rotary_knob_led_cursor.sv @@
// Takes one sample of the encoder pins and the push button per transfer and
// returns one result per sample, registered, in the cycle after the sample's
// transfer. A new sample is taken in every cycle that one is offered; the only
// thing that holds off a sample is the single result register still waiting
// to be taken. The display toggles r_ticks samples (written over i_cfg) after
// a rising push edge, and steps decoded while the display is off are dropped.
module rotary_knob_led_cursor
    import rklc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    rklc_in_if.sink     i_sample,
    rklc_cfg_if.sink    i_cfg,
    rklc_out_if.source  o_result
);

    logic  take;
    logic  busy;
    logic  display;
    t_step step;

    assign i_sample.ready = !busy;
    assign take           = i_sample.valid && !busy;

    rklc_decoder u_decoder (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_take  (take),
        .i_pin_a (i_sample.pin_a),
        .i_pin_b (i_sample.pin_b),
        .o_step  (step)
    );

    rklc_debounce u_debounce (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_take       (take),
        .i_push_level (i_sample.push_level),
        .i_cfg        (i_cfg),
        .o_display    (display)
    );

    rklc_cursor u_cursor (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_take    (take),
        .i_step    (step),
        .i_display (display),
        .o_busy    (busy),
        .o_result  (o_result)
    );

endmodule

@@ hw/rtl/rklc_checker.sv @@
`include "rotary_knob_led_cursor_assert.svh"

module rklc_checker
    import rklc_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_in_valid,
    input logic                  i_in_ready,
    input logic                  i_out_valid,
    input logic                  i_out_ready,
    input logic [LedW-1:0]       i_led_pattern,
    input logic [CursorOutW-1:0] i_cursor,
    input logic                  i_display_on
);

    `RKLC_ASSERT_NEXT(a_result_holds, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_led_pattern) && $stable(i_cursor) && $stable(i_display_on), "Stalled result changed.")

    `RKLC_ASSERT_NEXT(a_result_follows, i_clk, i_rst_n, i_in_valid && i_in_ready, i_out_valid, "No result after a sample transfer.")

    `RKLC_ASSERT_SAME(a_no_overrun, i_clk, i_rst_n, i_out_valid && !i_out_ready, !i_in_ready, "Sample taken while the result is stalled.")

    `RKLC_ASSERT_SAME(a_led_display, i_clk, i_rst_n, i_out_valid, (i_display_on && $onehot0(i_led_pattern)) || (!i_display_on && (i_led_pattern == '0)), "LED pattern disagrees with the display flag.")

endmodule

bind rotary_knob_led_cursor rklc_checker u_rklc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_sample.valid),
    .i_in_ready    (i_sample.ready),
    .i_out_valid   (o_result.valid),
    .i_out_ready   (o_result.ready),
    .i_led_pattern (o_result.led_pattern),
    .i_cursor      (o_result.cursor),
    .i_display_on  (o_result.display_on)
);
